// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the stepper controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_AT(lbl, clk, rstn, !(expr), msg)

`endif

// ----- hdl/sspc_pkg.sv -----
// Shared types and constants of the stepper speed/position controller.
// No dependencies; used by every module of the block.
package sspc_pkg;

  localparam int unsigned MOTORS    = 3;
  localparam int unsigned MotorIdxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int unsigned DivW      = 32;
  localparam int unsigned StepW     = 21;
  localparam int unsigned DivCntW   = $clog2(DivW);

  localparam logic [2:0] REG_CLOCK_HZ    = 3'd0;
  localparam logic [2:0] REG_MIN_PERIOD  = 3'd1;
  localparam logic [2:0] REG_MAX_PERIOD  = 3'd2;
  localparam logic [2:0] REG_DEADBAND    = 3'd3;
  localparam logic [2:0] REG_MOVE_SPEED  = 3'd4;
  localparam logic [2:0] REG_INVERT_MASK = 3'd5;

  localparam logic [31:0] RstClockHz   = 32'd10000000;
  localparam logic [15:0] RstMinPeriod = 16'd800;
  localparam logic [15:0] RstMaxPeriod = 16'd65535;
  localparam logic [15:0] RstDeadband  = 16'd15;
  localparam logic [22:0] RstMoveSpeed = 23'd7680;
  localparam logic [2:0]  RstInvMask   = 3'd6;
  localparam logic [15:0] RstPeriod    = 16'd65535;

  typedef enum logic [1:0] {
    FUNC_VELOCITY = 2'd0,
    FUNC_MOVE     = 2'd1,
    FUNC_PULSE    = 2'd2
  } func_e;

  typedef struct packed {
    logic [31:0] clock_hz;
    logic [15:0] min_period;
    logic [15:0] max_period;
    logic [15:0] deadband_q8;
    logic [22:0] move_speed_q8;
    logic [2:0]  invert_mask;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ----- hdl/sspc_cfg.sv -----
// APB configuration registers of the stepper controller.
// Depends on sspc_pkg for the register map and the cfg_t bundle.
module sspc_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sspc_pkg::cfg_t    cfg_o
);

  sspc_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_hz      <= sspc_pkg::RstClockHz;
      cfg_q.min_period    <= sspc_pkg::RstMinPeriod;
      cfg_q.max_period    <= sspc_pkg::RstMaxPeriod;
      cfg_q.deadband_q8   <= sspc_pkg::RstDeadband;
      cfg_q.move_speed_q8 <= sspc_pkg::RstMoveSpeed;
      cfg_q.invert_mask   <= sspc_pkg::RstInvMask;
    end else if (wr_en) begin
      unique case (idx)
        sspc_pkg::REG_CLOCK_HZ:    cfg_q.clock_hz      <= pwdata;
        sspc_pkg::REG_MIN_PERIOD:  cfg_q.min_period    <= pwdata[15:0];
        sspc_pkg::REG_MAX_PERIOD:  cfg_q.max_period    <= pwdata[15:0];
        sspc_pkg::REG_DEADBAND:    cfg_q.deadband_q8   <= pwdata[15:0];
        sspc_pkg::REG_MOVE_SPEED:  cfg_q.move_speed_q8 <= pwdata[22:0];
        sspc_pkg::REG_INVERT_MASK: cfg_q.invert_mask   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sspc_pkg::REG_CLOCK_HZ:    prdata = cfg_q.clock_hz;
      sspc_pkg::REG_MIN_PERIOD:  prdata = 32'(cfg_q.min_period);
      sspc_pkg::REG_MAX_PERIOD:  prdata = 32'(cfg_q.max_period);
      sspc_pkg::REG_DEADBAND:    prdata = 32'(cfg_q.deadband_q8);
      sspc_pkg::REG_MOVE_SPEED:  prdata = 32'(cfg_q.move_speed_q8);
      sspc_pkg::REG_INVERT_MASK: prdata = 32'(cfg_q.invert_mask);
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/sspc_serdiv.sv -----
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on sspc_pkg for widths; includes assert_macros.svh.
`include "assert_macros.svh"
module sspc_serdiv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sspc_pkg::DivW-1:0]        dividend_i,
  input  logic [sspc_pkg::StepW-1:0]       divisor_i,
  output logic [sspc_pkg::DivW-1:0]        quotient_o,
  output sspc_pkg::div_sts_t               sts_o
);

  logic [sspc_pkg::DivW-1:0]    quo_q;
  logic [sspc_pkg::StepW-1:0]   rem_q;
  logic [sspc_pkg::StepW-1:0]   dvs_q;
  logic [sspc_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic [sspc_pkg::StepW:0]     trial;
  logic [sspc_pkg::StepW:0]     diff;
  logic                         fits;

  assign trial = {rem_q, quo_q[sspc_pkg::DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[sspc_pkg::DivW-2:0], fits};
        rem_q <= fits ? diff[sspc_pkg::StepW-1:0] : trial[sspc_pkg::StepW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == sspc_pkg::DivCntW'(sspc_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

  `ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && busy_q, "divider restarted mid-run")
  `ASSERT_AT(a_done_follows_run, clk_i, rst_ni, done_q |-> $past(busy_q), "done without a run")
  `ASSERT_AT(a_done_single, clk_i, rst_ni, done_q |=> !done_q || $past(start_i), "done held")

endmodule

// ----- hdl/stepper_speed_position_controller_core.sv -----
// Step/direction rate controller for three stepper motors with one shared bit-serial divider.
// A velocity command runs two divisions: a division by 9 converts Q8 degrees to steps, then
// a second division turns the clock into the period.
// A move runs one conversion, and when it starts an idle motor a second conversion
// of the move speed and the period division follow. Step events, dead-band commands and
// unused codes skip the divider and pass from the decode state to the report state. The
// divider is the pacing unit; one item is processed at a time, and the next beat is taken while
// the finished result waits in the output register.
// Depends on sspc_pkg, sspc_cfg, sspc_serdiv and assert_macros.svh.
`include "assert_macros.svh"
module stepper_speed_position_controller_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,   // speed_q8[23:0], angle_q8[47:24], move_dir[48], pad
  input  logic [3:0]   s_axis_tuser,   // func[1:0], motor[3:2]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // period[15:0], compare[30:16], dir_pin[31],
                                       // timer_on[32], steps_left[64:33],
                                       // pulse_count[96:65], stopped_now[97], pad
  output logic [1:0]   m_axis_tuser,   // motor_out[1:0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_CONV, S_FREQ, S_MOVE, S_REPORT
  } state_e;

  localparam int unsigned MW = sspc_pkg::MotorIdxW;

  sspc_pkg::cfg_t     cfg;
  sspc_pkg::div_sts_t div_sts;
  logic [sspc_pkg::DivW-1:0]  div_quo;
  logic                       div_start;
  logic [sspc_pkg::DivW-1:0]  div_dividend;
  logic [sspc_pkg::StepW-1:0] div_divisor;

  state_e      state_q;
  logic [1:0]  func_q;
  logic [1:0]  motor_q;
  logic [23:0] speed_q;
  logic [23:0] angle_q;
  logic        mdir_q;
  logic        was_on_q;
  logic        conv_move_q;
  logic [sspc_pkg::StepW-1:0] steps_q;

  logic [31:0] rem_q  [sspc_pkg::MOTORS];
  logic [31:0] cnt_q  [sspc_pkg::MOTORS];
  logic        vrun_q [sspc_pkg::MOTORS];
  logic        ton_q  [sspc_pkg::MOTORS];
  logic [15:0] per_q  [sspc_pkg::MOTORS];
  logic        dir_q  [sspc_pkg::MOTORS];

  logic         m_valid_q;
  logic [103:0] m_data_q;
  logic [1:0]   m_user_q;

  logic          motor_ok;
  logic [MW-1:0] midx;
  logic          neg;
  logic [23:0]   mag;
  logic          in_band;
  logic [7:0]    inv8;
  logic          vel_dir;
  logic [23:0]   conv_in;
  logic [26:0]   conv_x5;
  logic [sspc_pkg::StepW-1:0] freq;
  logic [15:0]   per_hi;
  logic [15:0]   per_new;
  logic [32:0]   sum33;
  logic [31:0]   sum;
  logic          out_ok;
  logic [103:0]  rep_data;

  sspc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sspc_serdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .sts_o      (div_sts)
  );

  always_comb begin
    motor_ok = 32'(motor_q) < sspc_pkg::MOTORS;
    midx     = motor_ok ? MW'(motor_q) : '0;
    neg      = speed_q[23];
    mag      = neg ? (~speed_q + 24'd1) : speed_q;
    in_band  = mag <= 24'(cfg.deadband_q8);
    inv8     = 8'(cfg.invert_mask);
    vel_dir  = !neg ^ inv8[3'(midx)];

    if (state_q == S_MOVE) begin
      conv_in = 24'(cfg.move_speed_q8);
    end else if (func_q == sspc_pkg::FUNC_MOVE) begin
      conv_in = angle_q;
    end else begin
      conv_in = mag;
    end
    conv_x5 = {1'b0, conv_in, 2'b00} + 27'(conv_in);

    freq = (div_quo == '0) ? sspc_pkg::StepW'(1) : div_quo[sspc_pkg::StepW-1:0];
    if (state_q == S_CONV) begin
      div_dividend = cfg.clock_hz;
      div_divisor  = freq;
    end else begin
      div_dividend = 32'(conv_x5[26:3]);
      div_divisor  = sspc_pkg::StepW'(9);
    end

    per_hi  = (div_quo > 32'(cfg.max_period)) ? cfg.max_period : div_quo[15:0];
    per_new = (per_hi < cfg.min_period) ? cfg.min_period : per_hi;

    sum33 = {1'b0, rem_q[midx]} + 33'(steps_q);
    sum   = sum33[32] ? '1 : sum33[31:0];

    div_start = 1'b0;
    unique case (state_q)
      S_DECIDE: div_start = motor_ok &&
                            ((func_q == sspc_pkg::FUNC_VELOCITY && !in_band) ||
                             func_q == sspc_pkg::FUNC_MOVE);
      S_CONV:   div_start = div_sts.done && !conv_move_q;
      S_MOVE:   div_start = (sum != '0) && (rem_q[midx] == '0);
      default:  div_start = 1'b0;
    endcase

    out_ok = !m_valid_q || m_axis_tready;
    if (motor_ok) begin
      rep_data = {6'b0, was_on_q && !ton_q[midx], cnt_q[midx], rem_q[midx], ton_q[midx],
                  dir_q[midx], per_q[midx][15:1], per_q[midx]};
    end else begin
      rep_data = '0;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= '0;
      motor_q     <= '0;
      speed_q     <= '0;
      angle_q     <= '0;
      mdir_q      <= 1'b0;
      was_on_q    <= 1'b0;
      conv_move_q <= 1'b0;
      steps_q     <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_user_q    <= '0;
      for (int i = 0; i < sspc_pkg::MOTORS; i++) begin
        rem_q[i]  <= '0;
        cnt_q[i]  <= '0;
        vrun_q[i] <= 1'b0;
        ton_q[i]  <= 1'b0;
        per_q[i]  <= sspc_pkg::RstPeriod;
        dir_q[i]  <= 1'b1;
      end
    end else begin
      if (state_q == S_REPORT && out_ok) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func_q  <= s_axis_tuser[1:0];
            motor_q <= s_axis_tuser[3:2];
            speed_q <= s_axis_tdata[23:0];
            angle_q <= s_axis_tdata[47:24];
            mdir_q  <= s_axis_tdata[48];
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          was_on_q <= motor_ok && ton_q[midx];
          state_q  <= S_REPORT;
          if (motor_ok) begin
            unique case (func_q)
              sspc_pkg::FUNC_VELOCITY: begin
                if (in_band) begin
                  if (vrun_q[midx]) begin
                    ton_q[midx]  <= 1'b0;
                    vrun_q[midx] <= 1'b0;
                  end
                end else begin
                  dir_q[midx] <= vel_dir;
                  if (!vrun_q[midx]) begin
                    ton_q[midx]  <= 1'b1;
                    vrun_q[midx] <= 1'b1;
                  end
                  conv_move_q <= 1'b0;
                  state_q     <= S_CONV;
                end
              end
              sspc_pkg::FUNC_MOVE: begin
                dir_q[midx] <= mdir_q;
                conv_move_q <= 1'b1;
                state_q     <= S_CONV;
              end
              sspc_pkg::FUNC_PULSE: begin
                cnt_q[midx] <= cnt_q[midx] + 32'd1;
                if (rem_q[midx] != '0) begin
                  rem_q[midx] <= rem_q[midx] - 32'd1;
                  if (rem_q[midx] == 32'd1) begin
                    ton_q[midx] <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_CONV: begin
          if (div_sts.done) begin
            if (conv_move_q) begin
              steps_q <= div_quo[sspc_pkg::StepW-1:0];
              state_q <= S_MOVE;
            end else begin
              state_q <= S_FREQ;
            end
          end
        end
        S_FREQ: begin
          if (div_sts.done) begin
            per_q[midx] <= per_new;
            state_q     <= S_REPORT;
          end
        end
        S_MOVE: begin
          rem_q[midx] <= sum;
          state_q     <= S_REPORT;
          if (sum != '0) begin
            ton_q[midx] <= 1'b1;
            if (rem_q[midx] == '0) begin
              conv_move_q <= 1'b0;
              state_q     <= S_CONV;
            end
          end
        end
        S_REPORT: begin
          if (out_ok) begin
            m_data_q <= rep_data;
            m_user_q <= motor_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_ready_while_dividing, clk_i, rst_ni, s_axis_tready && div_sts.busy, "ready during division")
  `ASSERT_AT(a_report_loads, clk_i, rst_ni, (state_q == S_REPORT && !m_valid_q) |=> m_valid_q, "result not loaded")
  `ASSERT_AT(a_stop_means_off, clk_i, rst_ni, (m_valid_q && m_data_q[97]) |-> !m_data_q[32], "stopped but running")

endmodule

// ----- dv/tb_stepper_speed_position_controller_core.sv -----
// Self-checking testbench for the three-motor step/direction rate controller core.
// It drives command beats and APB register writes, and it checks every status beat
// against a predictor held in a small scoreboard class. Depends on sspc_pkg and the core RTL.
module tb_stepper_speed_position_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FuncUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  motor;
    logic [23:0] speed;
    logic [23:0] angle;
    logic        move_dir;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  motor;
    logic [15:0] period;
    logic [14:0] compare;
    logic        dir;
    logic        timer_on;
    logic [31:0] steps;
    logic [31:0] pulses;
    logic        stopped;
  } status_t;

  class motor_status_scoreboard;
    sspc_pkg::cfg_t cfg;
    logic [31:0] steps_left [sspc_pkg::MOTORS];
    logic [31:0] pulse_count [sspc_pkg::MOTORS];
    logic        vel_mode [sspc_pkg::MOTORS];
    logic        timer_on [sspc_pkg::MOTORS];
    logic [15:0] period [sspc_pkg::MOTORS];
    logic        dir_level [sspc_pkg::MOTORS];
    status_t     status_due_q [$];
    int          errors;

    function new();
      cfg.clock_hz      = sspc_pkg::RstClockHz;
      cfg.min_period    = sspc_pkg::RstMinPeriod;
      cfg.max_period    = sspc_pkg::RstMaxPeriod;
      cfg.deadband_q8   = sspc_pkg::RstDeadband;
      cfg.move_speed_q8 = sspc_pkg::RstMoveSpeed;
      cfg.invert_mask   = sspc_pkg::RstInvMask;
      for (int m = 0; m < sspc_pkg::MOTORS; m++) begin
        steps_left[m]  = '0;
        pulse_count[m] = '0;
        vel_mode[m]    = 1'b0;
        timer_on[m]    = 1'b0;
        period[m]      = sspc_pkg::RstPeriod;
        dir_level[m]   = 1'b1;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        sspc_pkg::REG_CLOCK_HZ:    cfg.clock_hz      = val;
        sspc_pkg::REG_MIN_PERIOD:  cfg.min_period    = val[15:0];
        sspc_pkg::REG_MAX_PERIOD:  cfg.max_period    = val[15:0];
        sspc_pkg::REG_DEADBAND:    cfg.deadband_q8   = val[15:0];
        sspc_pkg::REG_MOVE_SPEED:  cfg.move_speed_q8 = val[22:0];
        sspc_pkg::REG_INVERT_MASK: cfg.invert_mask   = val[2:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] q8_to_steps(logic [31:0] q8);
      logic [63:0] prod;
      prod = {32'd0, q8} * 64'd5;
      return 32'(prod / 64'd72);
    endfunction

    function void load_period(int m, logic [31:0] mag);
      logic [31:0] freq;
      logic [31:0] p;
      freq = q8_to_steps(mag);
      if (freq == 0) freq = 32'd1;
      p = cfg.clock_hz / freq;
      if (p > {16'd0, cfg.max_period}) p = {16'd0, cfg.max_period};
      if (p < {16'd0, cfg.min_period}) p = {16'd0, cfg.min_period};
      period[m] = p[15:0];
    endfunction

    function void apply_command(cmd_t c);
      status_t     s;
      int          m;
      logic        was_on;
      logic        neg;
      logic        was_idle;
      logic [23:0] mag24;
      logic [31:0] mag;
      logic [31:0] add;
      logic [31:0] sum;
      s = '0;
      s.motor = c.motor;
      if (c.motor >= sspc_pkg::MOTORS) begin
        status_due_q.push_back(s);
        return;
      end
      m = int'(c.motor);
      was_on = timer_on[m];
      case (c.func)
        sspc_pkg::FUNC_VELOCITY: begin
          neg = c.speed[23];
          mag24 = neg ? (24'd0 - c.speed) : c.speed;
          mag = {8'd0, mag24};
          if (mag <= {16'd0, cfg.deadband_q8}) begin
            if (vel_mode[m]) begin
              timer_on[m] = 1'b0;
              vel_mode[m] = 1'b0;
            end
          end else begin
            dir_level[m] = ~neg ^ cfg.invert_mask[m];
            load_period(m, mag);
            if (!vel_mode[m]) begin
              timer_on[m] = 1'b1;
              vel_mode[m] = 1'b1;
            end
          end
        end
        sspc_pkg::FUNC_MOVE: begin
          add = q8_to_steps({8'd0, c.angle});
          was_idle = (steps_left[m] == 0);
          sum = steps_left[m] + add;
          if (sum < add) sum = '1;
          dir_level[m] = c.move_dir;
          steps_left[m] = sum;
          if (sum != 0) begin
            if (was_idle) load_period(m, {9'd0, cfg.move_speed_q8});
            timer_on[m] = 1'b1;
          end
        end
        sspc_pkg::FUNC_PULSE: begin
          pulse_count[m] = pulse_count[m] + 32'd1;
          if (steps_left[m] != 0) begin
            steps_left[m] = steps_left[m] - 32'd1;
            if (steps_left[m] == 0) timer_on[m] = 1'b0;
          end
        end
        default: ;
      endcase
      s.period   = period[m];
      s.compare  = period[m][15:1];
      s.dir      = dir_level[m];
      s.timer_on = timer_on[m];
      s.steps    = steps_left[m];
      s.pulses   = pulse_count[m];
      s.stopped  = was_on & ~timer_on[m];
      status_due_q.push_back(s);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_status(status_t got);
      status_t want;
      if (status_due_q.size() == 0) begin
        report_mismatch("unexpected status beat, motor", 32'(got.motor), '0);
        return;
      end
      want = status_due_q.pop_front();
      if (got.motor !== want.motor)
        report_mismatch("motor_out", 32'(got.motor), 32'(want.motor));
      if (got.period !== want.period)
        report_mismatch("period", 32'(got.period), 32'(want.period));
      if (got.compare !== want.compare)
        report_mismatch("compare", 32'(got.compare), 32'(want.compare));
      if (got.dir !== want.dir) report_mismatch("dir_pin", 32'(got.dir), 32'(want.dir));
      if (got.timer_on !== want.timer_on)
        report_mismatch("timer_on", 32'(got.timer_on), 32'(want.timer_on));
      if (got.steps !== want.steps) report_mismatch("steps_left", got.steps, want.steps);
      if (got.pulses !== want.pulses) report_mismatch("pulse_count", got.pulses, want.pulses);
      if (got.stopped !== want.stopped)
        report_mismatch("stopped_now", 32'(got.stopped), 32'(want.stopped));
    endtask

    function int pending();
      return status_due_q.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;
  logic [3:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  motor_status_scoreboard sb;
  status_t seen;
  bit      steady;
  bit      hold_req;
  int      items_sent;

  stepper_speed_position_controller_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #80ms;
    $display("tb_stepper_speed_position_controller_core NOT OK");
    $finish;
  end

  // The receiver stalls at random, and holds off for a long stretch when asked to.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready && sb != null) begin
      seen.motor    = m_axis_tuser;
      seen.period   = m_axis_tdata[15:0];
      seen.compare  = m_axis_tdata[30:16];
      seen.dir      = m_axis_tdata[31];
      seen.timer_on = m_axis_tdata[32];
      seen.steps    = m_axis_tdata[64:33];
      seen.pulses   = m_axis_tdata[96:65];
      seen.stopped  = m_axis_tdata[97];
      sb.check_status(seen);
    end
  end

  task automatic send_command(input cmd_t c);
    if (!steady && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, c.move_dir, c.angle, c.speed};
    s_axis_tuser  <= {c.motor, c.func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.apply_command(c);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] clock_hz, input logic [15:0] min_p,
                           input logic [15:0] max_p, input logic [15:0] deadband,
                           input logic [22:0] move_speed, input logic [2:0] inv_mask);
    write_reg(sspc_pkg::REG_CLOCK_HZ, clock_hz);
    write_reg(sspc_pkg::REG_MIN_PERIOD, {16'd0, min_p});
    write_reg(sspc_pkg::REG_MAX_PERIOD, {16'd0, max_p});
    write_reg(sspc_pkg::REG_DEADBAND, {16'd0, deadband});
    write_reg(sspc_pkg::REG_MOVE_SPEED, {9'd0, move_speed});
    write_reg(sspc_pkg::REG_INVERT_MASK, {29'd0, inv_mask});
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.func     = 2'($urandom_range(0, 3));
    c.motor    = 2'($urandom_range(0, 3));
    c.speed    = 24'($urandom());
    c.angle    = 24'($urandom());
    c.move_dir = 1'($urandom());
    return c;
  endfunction

  task automatic send_one(input logic [1:0] func, input logic [1:0] motor,
                          input logic [23:0] speed, input logic [23:0] angle,
                          input logic move_dir);
    cmd_t c;
    c.func     = func;
    c.motor    = motor;
    c.speed    = speed;
    c.angle    = angle;
    c.move_dir = move_dir;
    send_command(c);
  endtask

  task automatic run_random(input int count);
    cmd_t       c;
    int         start;
    int         k;
    int         v;
    int         pulses;
    logic [1:0] mv;
    start = items_sent;
    while (items_sent - start < count) begin
      c = random_cmd();
      c.motor = 2'($urandom_range(0, 2));
      k = $urandom_range(99);
      if (k < 35) begin
        c.func  = sspc_pkg::FUNC_MOVE;
        c.angle = 24'($urandom_range(0, 400));
        mv      = c.motor;
        send_command(c);
        if (sb.steps_left[mv] <= 40) begin
          pulses = sb.steps_left[mv] + $urandom_range(0, 2);
          repeat (pulses) begin
            c = random_cmd();
            c.func  = sspc_pkg::FUNC_PULSE;
            c.motor = mv;
            if ($urandom_range(9) == 0) c.func = sspc_pkg::FUNC_VELOCITY;
            send_command(c);
          end
        end
      end else if (k < 60) begin
        c.func = sspc_pkg::FUNC_VELOCITY;
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            v = int'(sb.cfg.deadband_q8) + $urandom_range(0, 2) - 1;
            if (v < 0) v = 0;
            c.speed = c.speed[0] ? 24'(-v) : 24'(v);
          end
          2: begin
            v = $urandom_range(0, 5000);
            c.speed = c.speed[0] ? 24'(-v) : 24'(v);
          end
          default: c.speed = 24'($urandom_range(0, 16)) - 24'd8;
        endcase
        send_command(c);
      end else if (k < 80) begin
        c.func = sspc_pkg::FUNC_PULSE;
        send_command(c);
      end else if (k < 90) begin
        c.func = FuncUnused;
        send_command(c);
      end else begin
        c.motor = 2'd3;
        send_command(c);
      end
    end
  endtask

  task automatic run_random_config(input int count);
    logic [15:0] min_p;
    min_p = 16'($urandom_range(1, 3000));
    write_all($urandom_range(1000, 100_000_000), min_p, 16'($urandom_range(min_p, 65535)),
              16'($urandom_range(0, 2000)), 23'($urandom_range(0, 200_000)),
              3'($urandom_range(0, 7)));
    run_random(count);
    wait_idle();
  endtask

  initial begin
    int guard;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    items_sent    = 0;
    sb = new();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats under the reset register values.
    send_one(sspc_pkg::FUNC_PULSE, 2'd0, 24'd0, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd0, 24'd0, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd0, 24'd15, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd0, 24'd16, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd0, 24'h7F_FFFF, 24'hFF_FFFF, 1'b1);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd0, 24'hFF_FFF0, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd0, 24'hFF_FFF1, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd1, 24'h80_0000, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd1, 24'd0, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_MOVE, 2'd2, 24'd0, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_MOVE, 2'd2, 24'd0, 24'd72, 1'b1);
    send_one(sspc_pkg::FUNC_MOVE, 2'd2, 24'd0, 24'd30, 1'b1);
    repeat (8) send_one(sspc_pkg::FUNC_PULSE, 2'd2, 24'd0, 24'd0, 1'b0);
    send_one(FuncUnused, 2'd0, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd3, 24'h12_3456, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_MOVE, 2'd3, 24'd0, 24'hFF_FFFF, 1'b1);
    send_one(sspc_pkg::FUNC_PULSE, 2'd3, 24'd0, 24'd0, 1'b0);
    send_one(FuncUnused, 2'd3, 24'd0, 24'd0, 1'b0);

    hold_req = 1'b1;
    run_random(150);
    wait_idle();

    write_all(32'hFFFF_FFFF, 16'd1, 16'd65535, 16'd0, 23'h7F_FFFF, 3'd7);
    steady = 1'b1;
    run_random(120);
    steady = 1'b0;
    run_random(100);
    wait_idle();

    // Crossed clamps: the lower clamp takes precedence.
    write_all(32'd1, 16'd65535, 16'd1, 16'd65535, 23'd0, 3'd0);
    run_random(150);
    wait_idle();

    run_random_config(200);
    run_random_config(200);

    write_all(32'd10_000_000, 16'd100, 16'd40000, 16'd256, 23'd2560, 3'd5);
    run_random(240);

    // Long moves pile up a large step count on one motor.
    guard = 0;
    while (sb.steps_left[2] != 32'hFFFF_FFFF && guard < 24) begin
      send_one(sspc_pkg::FUNC_MOVE, 2'd2, 24'($urandom()), 24'hFF_FFFF, 1'($urandom()));
      guard++;
    end
    send_one(sspc_pkg::FUNC_MOVE, 2'd2, 24'd0, 24'hFF_FFFF, 1'b0);
    send_one(sspc_pkg::FUNC_PULSE, 2'd2, 24'd0, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_MOVE, 2'd2, 24'd0, 24'd720, 1'b1);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd2, 24'hF0_0000, 24'd0, 1'b0);
    send_one(sspc_pkg::FUNC_VELOCITY, 2'd2, 24'd0, 24'd0, 1'b0);

    wait_idle();
    repeat (150) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_stepper_speed_position_controller_core OK");
    end else begin
      $display("tb_stepper_speed_position_controller_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/sspc_pkg.sv
hdl/sspc_cfg.sv
hdl/sspc_serdiv.sv
hdl/stepper_speed_position_controller_core.sv
dv/tb_stepper_speed_position_controller_core.sv
